[design/kdar_pkg.sv]
package kdar_pkg;

  localparam int unsigned BUTTON_WIDTH = 16;
  localparam int unsigned TICK_WIDTH   = 32;
  localparam int unsigned COUNT_WIDTH  = 4;
  localparam int unsigned CFG_IDX_WIDTH = 2;

  // Only the low BUTTON_WIDTH lanes of a 16-bit pattern are live.
  localparam logic [15:0] ButtonMask = 16'((32'd1 << BUTTON_WIDTH) - 32'd1);

  localparam logic [COUNT_WIDTH-1:0] CountMax       = '1;
  localparam logic [COUNT_WIDTH-1:0] StableSamplesRst = 4'd2;
  localparam logic [TICK_WIDTH-1:0]  RepeatDelayRst = 32'd500;
  localparam logic [TICK_WIDTH-1:0]  RepeatRateRst  = 32'd100;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_STABLE_SAMPLES = 2'd0,
    CFG_REPEAT_DELAY   = 2'd1,
    CFG_REPEAT_RATE    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_QUAL   = 4'b0010,
    PH_STABLE = 4'b0100,
    PH_REPEAT = 4'b1000
  } phase_e;

  typedef struct packed {
    logic        sample_valid;
    logic [15:0] button_bits;
    logic [31:0] now_ticks;
  } sample_req_t;

  typedef struct packed {
    logic [15:0] changed_bits;
    logic [15:0] pressed_bits;
    logic        is_repeat;
  } key_rsp_t;

endpackage

[design/keypad_debounce_autorepeat.sv]
// Channel   Direction  Handshake                Payload
// in        request    in_valid_i / in_ready_o  kdar_pkg::sample_req_t
// out       result     out_valid_o/out_ready_i  kdar_pkg::key_rsp_t
// cfg       write      cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
// One request per clock while the output register is free or being drained.
// The state update and the result are formed combinationally from the
// incoming request and the debounce state; the result lands in the output register.
// The output register is the only stall point: a new request is taken while
// the held result is being drained, so a stalled consumer costs nothing more.
// Reset restores the register defaults (2 / 500 / 100) and returns to idle.
module keypad_debounce_autorepeat (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  kdar_pkg::sample_req_t                  in_req_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output kdar_pkg::key_rsp_t                     out_rsp_o,
  input  logic                                   cfg_we_i,
  input  logic [kdar_pkg::CFG_IDX_WIDTH-1:0]     cfg_idx_i,
  input  logic [kdar_pkg::TICK_WIDTH-1:0]        cfg_wdata_i
);

  // Configuration registers
  logic [kdar_pkg::COUNT_WIDTH-1:0] stable_samples_q;
  logic [kdar_pkg::TICK_WIDTH-1:0]  repeat_delay_q, repeat_rate_q;

  // Debounce state
  kdar_pkg::phase_e                 phase_q, phase_d;
  logic [15:0]                      cand_q, cand_d;
  logic [15:0]                      stable_q, stable_d;
  logic [15:0]                      held_chg_q, held_chg_d;
  logic [kdar_pkg::COUNT_WIDTH-1:0] match_cnt_q, match_cnt_d;
  logic [kdar_pkg::TICK_WIDTH-1:0]  deadline_q, deadline_d;

  // Output register
  logic                             out_valid_q;
  kdar_pkg::key_rsp_t               out_rsp_q;

  logic                             in_fire;
  logic                             res_valid;
  kdar_pkg::key_rsp_t               res;
  logic [15:0]                      bits;
  logic [15:0]                      changed;
  logic [kdar_pkg::COUNT_WIDTH-1:0] cnt_inc;

  // Output slot is free when empty or being drained this cycle.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign bits    = in_req_i.button_bits & kdar_pkg::ButtonMask;
  assign changed = stable_q ^ cand_q;
  // Saturating match counter.
  assign cnt_inc = (match_cnt_q == kdar_pkg::CountMax) ? match_cnt_q
                                                       : match_cnt_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    cand_d      = cand_q;
    stable_d    = stable_q;
    held_chg_d  = held_chg_q;
    match_cnt_d = match_cnt_q;
    deadline_d  = deadline_q;
    res_valid   = 1'b0;
    res         = '0;
    unique case (phase_q)
      kdar_pkg::PH_IDLE: begin
        // A new raw pattern starts qualification.
        if (bits != cand_q) begin
          cand_d      = bits;
          phase_d     = kdar_pkg::PH_QUAL;
          match_cnt_d = '0;
        end
      end
      kdar_pkg::PH_QUAL: begin
        if (bits == cand_q) begin
          match_cnt_d = cnt_inc;
          // Threshold of zero behaves like one since the count is already >= 1.
          if (cnt_inc >= stable_samples_q) begin
            phase_d = kdar_pkg::PH_STABLE;
          end
        end else begin
          // Bounce: drop back, candidate kept.
          phase_d = kdar_pkg::PH_IDLE;
        end
      end
      kdar_pkg::PH_STABLE: begin
        // Report on the sample after qualification; raw bits are not looked at.
        stable_d   = cand_q;
        held_chg_d = changed;
        if (cand_q != '0) begin
          phase_d    = kdar_pkg::PH_REPEAT;
          deadline_d = in_req_i.now_ticks + repeat_delay_q;
        end else begin
          phase_d = kdar_pkg::PH_IDLE;
        end
        res_valid        = (changed != '0) || (cand_q != '0);
        res.changed_bits = changed;
        res.pressed_bits = cand_q;
        res.is_repeat    = 1'b0;
      end
      kdar_pkg::PH_REPEAT: begin
        if (bits != cand_q) begin
          phase_d = kdar_pkg::PH_IDLE;
        end else if (in_req_i.now_ticks >= deadline_q) begin
          deadline_d       = in_req_i.now_ticks + repeat_rate_q;
          res_valid        = (held_chg_q != '0) || (stable_q != '0);
          res.changed_bits = held_chg_q;
          res.pressed_bits = stable_q;
          res.is_repeat    = 1'b1;
        end
      end
      default: begin
        phase_d = kdar_pkg::PH_IDLE;
      end
    endcase
    // Invalid samples leave everything untouched.
    if (!in_req_i.sample_valid) begin
      phase_d     = phase_q;
      cand_d      = cand_q;
      stable_d    = stable_q;
      held_chg_d  = held_chg_q;
      match_cnt_d = match_cnt_q;
      deadline_d  = deadline_q;
      res_valid   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_samples_q <= kdar_pkg::StableSamplesRst;
      repeat_delay_q   <= kdar_pkg::RepeatDelayRst;
      repeat_rate_q    <= kdar_pkg::RepeatRateRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kdar_pkg::CFG_STABLE_SAMPLES:
          stable_samples_q <= cfg_wdata_i[kdar_pkg::COUNT_WIDTH-1:0];
        kdar_pkg::CFG_REPEAT_DELAY: repeat_delay_q <= cfg_wdata_i;
        kdar_pkg::CFG_REPEAT_RATE:  repeat_rate_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= kdar_pkg::PH_IDLE;
      cand_q      <= '0;
      stable_q    <= '0;
      held_chg_q  <= '0;
      match_cnt_q <= '0;
      deadline_q  <= '0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      cand_q      <= cand_d;
      stable_q    <= stable_d;
      held_chg_q  <= held_chg_d;
      match_cnt_q <= match_cnt_d;
      deadline_q  <= deadline_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_rsp_q <= res;
    end
  end

  // Repeating only ever follows a nonzero stable pattern.
  a_repeat_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == kdar_pkg::PH_REPEAT |-> stable_q != '0)
    else $error("repeat phase with empty stable pattern");

  // A report always carries something.
  a_result_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.changed_bits != '0) || (out_rsp_o.pressed_bits != '0))
    else $error("empty report emitted");

  // Auto repeats only while buttons are held.
  a_repeat_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.is_repeat |-> out_rsp_o.pressed_bits != '0)
    else $error("auto repeat without pressed buttons");

  // The stable phase lasts exactly one valid sample.
  a_stable_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_req_i.sample_valid && phase_q == kdar_pkg::PH_STABLE
      |=> phase_q != kdar_pkg::PH_STABLE)
    else $error("stable phase not left after report sample");

endmodule
